@@ src/mmp_pkg.sv @@
// shared constants, codes and item types of the min/max peak pyramid
package mmp_pkg;

  localparam int unsigned SampW      = 16;
  localparam int unsigned CntW       = 32;
  localparam int unsigned BaseWindow = 256;
  localparam int unsigned GroupSize  = 4;
  localparam int unsigned TopLimit   = 2048;
  localparam int unsigned MaxLevels  = 8;
  localparam longint unsigned MaxPeakPairs = 64'd33554432;

  localparam int unsigned FillW = $clog2(BaseWindow + 1);
  localparam int unsigned LvlW  = $clog2(MaxLevels);
  localparam int unsigned LuW   = $clog2(MaxLevels + 1);
  localparam int unsigned PlanW = CntW + 2;

  localparam logic signed [SampW-1:0] SampMax = {1'b0, {(SampW-1){1'b1}}};
  localparam logic signed [SampW-1:0] SampMin = {1'b1, {(SampW-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_PLAN  = 2'd1,
    STAT_COUNT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic signed [SampW-1:0] sample;
    logic                    last_sample;
  } in_item_t;

  typedef struct packed {
    logic [LvlW-1:0]         level;
    logic signed [SampW-1:0] peak_min;
    logic signed [SampW-1:0] peak_max;
    logic                    last_peak;
    status_e                 status;
  } out_item_t;

  // token that climbs the chain of level cells
  typedef struct packed {
    logic                    valid;
    logic                    has;
    logic                    last;
    logic signed [SampW-1:0] mn;
    logic signed [SampW-1:0] mx;
  } tok_t;

  // what a cell reports to the controller in the cycle it takes the token
  typedef struct packed {
    logic                    valid;
    logic                    done;
    logic signed [SampW-1:0] mn;
    logic signed [SampW-1:0] mx;
  } cell_evt_t;

endpackage

@@ src/mmp_if.sv @@
// valid/ready stream interfaces for the sample and peak channels
interface mmp_in_if;
  logic               valid;
  logic               ready;
  mmp_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmp_out_if;
  logic               valid;
  logic               ready;
  mmp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/minmax_peak_pyramid.sv @@
// top level: min/max peak pyramid over a signed sample stream
// a sample climbs one level cell per cycle while the output register is not stalled; a peak
//   waits in the pending register and moves to the output register on the next peak or at the end
// a new sample is not taken until the token walk through the cell chain and the final
//   state are over
// config: after a sample_count write the planner runs, input not ready meanwhile
// reset: no plan (levels 0), all levels empty, so the first sample gives a plan error
module minmax_peak_pyramid (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mmp_pkg::CntW-1:0] cfg_wdata_i,
  mmp_in_if.sink                   in_i,
  mmp_out_if.source                out_o
);

  mmp_pkg::ctrl_state_e state_q, state_d;

  logic [mmp_pkg::CntW-1:0]  count_q, seen_q;
  logic [mmp_pkg::CntW:0]    seen_after;
  logic                      err_seen_q;
  logic                      plan_busy;
  logic [mmp_pkg::LuW-1:0]   levels_used;

  // out_q is the channel register, pend_q holds the newest peak until we know
  // whether another one follows (that decides last_peak)
  mmp_pkg::out_item_t        out_q, pend_q;
  logic                      out_vq, pend_vq;

  mmp_pkg::tok_t             tok [mmp_pkg::MaxLevels+1];
  mmp_pkg::cell_evt_t        evt [mmp_pkg::MaxLevels];
  mmp_pkg::tok_t             inj_q;

  logic                      out_free, in_ready, acc, adv, run_ok, cell_clear, out_load;
  mmp_pkg::status_e          err;
  logic                      evt_v, evt_done;
  logic [mmp_pkg::LvlW-1:0]  evt_lvl;
  logic signed [mmp_pkg::SampW-1:0] evt_mn, evt_mx;

  mmp_plan u_plan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_we_i),
    .count_i  (cfg_wdata_i),
    .busy_o   (plan_busy),
    .levels_o (levels_used)
  );

  // cell 0 takes the injected sample token, each cell feeds the next
  assign tok[0] = inj_q;

  for (genvar l = 0; l < mmp_pkg::MaxLevels; l++) begin : g_cell
    mmp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .clear_i (cell_clear),
      .base_i  (l == 0),
      .top_i   (levels_used == mmp_pkg::LuW'(l + 1)),
      .tok_i   (tok[l]),
      .tok_o   (tok[l+1]),
      .evt_o   (evt[l])
    );
  end

  // only one cell holds the token, so at most one reports per cycle
  always_comb begin
    evt_v    = 1'b0;
    evt_done = 1'b0;
    evt_lvl  = '0;
    evt_mn   = '0;
    evt_mx   = '0;
    for (int l = 0; l < mmp_pkg::MaxLevels; l++) begin
      if (evt[l].valid) begin
        evt_v   = 1'b1;
        evt_lvl = mmp_pkg::LvlW'(l);
        evt_mn  = evt[l].mn;
        evt_mx  = evt[l].mx;
      end
      if (evt[l].done) begin
        evt_done = 1'b1;
      end
    end
  end

  always_comb begin
    out_free   = !out_vq || out_o.ready;
    in_ready   = (state_q == mmp_pkg::S_IDLE) && !plan_busy;
    acc        = in_i.valid && in_ready;
    adv        = (state_q == mmp_pkg::S_WALK) && out_free;
    seen_after = {1'b0, seen_q} + (mmp_pkg::CntW+1)'(1);

    // the pending peak moves into the channel register on the next peak or at the end
    out_load   = pend_vq && (((state_q == mmp_pkg::S_WALK) && adv && evt_v) ||
                             ((state_q == mmp_pkg::S_FIN) && out_free));

    // error check, plan first, then too many, then too few at the last sample
    priority if ((levels_used == '0) || (levels_used > mmp_pkg::LuW'(mmp_pkg::MaxLevels))) begin
      err = mmp_pkg::STAT_PLAN;
    end else if (seen_after > {1'b0, count_q}) begin
      err = mmp_pkg::STAT_COUNT;
    end else if (in_i.data.last_sample && (seen_after != {1'b0, count_q})) begin
      err = mmp_pkg::STAT_COUNT;
    end else begin
      err = mmp_pkg::STAT_OK;
    end

    run_ok     = !err_seen_q && (err == mmp_pkg::STAT_OK);
    // a last sample on a failed or dead run drops whatever the levels hold
    cell_clear = cfg_we_i || (acc && in_i.data.last_sample && !run_ok);

    state_d = state_q;
    unique case (state_q)
      mmp_pkg::S_IDLE: begin
        if (acc && run_ok) begin
          state_d = mmp_pkg::S_WALK;
        end else if (acc && !err_seen_q) begin
          state_d = mmp_pkg::S_FIN;
        end
      end
      mmp_pkg::S_WALK: begin
        if (adv && evt_done) begin
          state_d = mmp_pkg::S_FIN;
        end
      end
      mmp_pkg::S_FIN: begin
        if (out_free) begin
          state_d = mmp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mmp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // run bookkeeping and sample injection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      seen_q     <= '0;
      err_seen_q <= 1'b0;
      inj_q      <= '0;
    end else if (cfg_we_i) begin
      count_q    <= cfg_wdata_i;
      seen_q     <= '0;
      err_seen_q <= 1'b0;
      inj_q      <= '0;
    end else begin
      if (adv) begin
        inj_q.valid <= 1'b0;
      end
      if (acc) begin
        if (err_seen_q) begin
          if (in_i.data.last_sample) begin
            seen_q     <= '0;
            err_seen_q <= 1'b0;
          end
        end else if (err != mmp_pkg::STAT_OK) begin
          if (in_i.data.last_sample) begin
            seen_q <= '0;
          end else begin
            err_seen_q <= 1'b1;
          end
        end else begin
          seen_q      <= in_i.data.last_sample ? '0 : seen_after[mmp_pkg::CntW-1:0];
          inj_q.valid <= 1'b1;
          inj_q.has   <= 1'b1;
          inj_q.last  <= in_i.data.last_sample;
          inj_q.mn    <= in_i.data.sample;
          inj_q.mx    <= in_i.data.sample;
        end
      end
    end
  end

  // result path: pending peak, then the channel register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      pend_vq <= 1'b0;
      out_q   <= '0;
      pend_q  <= '0;
    end else begin
      if (out_load) begin
        out_vq <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
      unique case (state_q)
        mmp_pkg::S_IDLE: begin
          if (acc && !err_seen_q && (err != mmp_pkg::STAT_OK)) begin
            pend_vq          <= 1'b1;
            pend_q.level     <= '0;
            pend_q.peak_min  <= '0;
            pend_q.peak_max  <= '0;
            pend_q.last_peak <= 1'b0;
            pend_q.status    <= err;
          end
        end
        mmp_pkg::S_WALK: begin
          if (adv && evt_v) begin
            if (pend_vq) begin
              out_q <= pend_q;
            end
            pend_vq          <= 1'b1;
            pend_q.level     <= evt_lvl;
            pend_q.peak_min  <= evt_mn;
            pend_q.peak_max  <= evt_mx;
            pend_q.last_peak <= 1'b0;
            pend_q.status    <= mmp_pkg::STAT_OK;
          end
        end
        mmp_pkg::S_FIN: begin
          // nothing follows, so the pending peak closes this item
          if (out_free && pend_vq) begin
            out_q.level     <= pend_q.level;
            out_q.peak_min  <= pend_q.peak_min;
            out_q.peak_max  <= pend_q.peak_max;
            out_q.last_peak <= 1'b1;
            out_q.status    <= pend_q.status;
            pend_vq         <= 1'b0;
          end
        end
        default: begin
          pend_vq <= 1'b0;
        end
      endcase
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_vq;
  assign out_o.data  = out_q;

endmodule

@@ src/mmp_cell.sv @@
// one pyramid level: running min/max and fill count, passes a token upward
module mmp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               clear_i,
  input  logic               base_i,
  input  logic               top_i,
  input  mmp_pkg::tok_t      tok_i,
  output mmp_pkg::tok_t      tok_o,
  output mmp_pkg::cell_evt_t evt_o
);

  logic signed [mmp_pkg::SampW-1:0] min_q, max_q, mn_m, mx_m;
  logic [mmp_pkg::FillW-1:0]        fill_q, fill_n;
  logic                             take, thr_hit, close, pass;
  mmp_pkg::tok_t                    tok_q, tok_d;

  always_comb begin
    take    = adv_i && tok_i.valid;
    mn_m    = (tok_i.has && (tok_i.mn < min_q)) ? tok_i.mn : min_q;
    mx_m    = (tok_i.has && (tok_i.mx > max_q)) ? tok_i.mx : max_q;
    fill_n  = fill_q + mmp_pkg::FillW'(tok_i.has);
    thr_hit = base_i ? (fill_n >= mmp_pkg::FillW'(mmp_pkg::BaseWindow))
                     : (fill_n >= mmp_pkg::FillW'(mmp_pkg::GroupSize));
    close   = (tok_i.has && thr_hit) || (tok_i.last && (fill_n != '0));
    // a flush keeps climbing even past a level with nothing to close
    pass    = !top_i && (close || tok_i.last);

    tok_d = tok_q;
    if (adv_i) begin
      tok_d.valid = take && pass;
      tok_d.has   = close;
      tok_d.last  = tok_i.last;
      tok_d.mn    = mn_m;
      tok_d.mx    = mx_m;
    end

    evt_o.valid = take && close;
    evt_o.done  = take && !pass;
    evt_o.mn    = mn_m;
    evt_o.mx    = mx_m;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= mmp_pkg::SampMax;
      max_q  <= mmp_pkg::SampMin;
      fill_q <= '0;
      tok_q  <= '0;
    end else if (clear_i) begin
      min_q  <= mmp_pkg::SampMax;
      max_q  <= mmp_pkg::SampMin;
      fill_q <= '0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (take) begin
        if (close) begin
          min_q  <= mmp_pkg::SampMax;
          max_q  <= mmp_pkg::SampMin;
          fill_q <= '0;
        end else begin
          min_q  <= mn_m;
          max_q  <= mx_m;
          fill_q <= fill_n;
        end
      end
    end
  end

  assign tok_o = tok_q;

endmodule

@@ src/mmp_plan.sv @@
// iterative level planner, one pyramid level per cycle after a count write
module mmp_plan (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [mmp_pkg::CntW-1:0] count_i,
  output logic                    busy_o,
  output logic [mmp_pkg::LuW-1:0] levels_o
);

  localparam logic [mmp_pkg::PlanW-1:0] MaxPairs = mmp_pkg::PlanW'(mmp_pkg::MaxPeakPairs);
  localparam logic [mmp_pkg::PlanW-1:0] SppLimit = mmp_pkg::PlanW'(64'hFFFFFFFF / 4);

  logic                           busy_q, bad_q;
  logic [mmp_pkg::PlanW-1:0]      cur_q, tot_q, spp_q, base, nxt;
  logic [mmp_pkg::LuW-1:0]        lc_q, lu_q;

  always_comb begin
    base = mmp_pkg::PlanW'(count_i / mmp_pkg::BaseWindow)
         + mmp_pkg::PlanW'((count_i % mmp_pkg::BaseWindow) != 0);
    nxt  = (cur_q / mmp_pkg::GroupSize)
         + mmp_pkg::PlanW'((cur_q % mmp_pkg::GroupSize) != 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
      lu_q   <= '0;
      lc_q   <= '0;
      cur_q  <= '0;
      tot_q  <= '0;
      spp_q  <= '0;
    end else if (we_i) begin
      busy_q <= 1'b1;
      bad_q  <= (base == '0) || (base > MaxPairs);
      lu_q   <= '0;
      lc_q   <= mmp_pkg::LuW'(1);
      cur_q  <= base;
      tot_q  <= base;
      spp_q  <= mmp_pkg::PlanW'(mmp_pkg::BaseWindow);
    end else if (busy_q) begin
      if (bad_q) begin
        busy_q <= 1'b0;
      end else if (cur_q <= mmp_pkg::PlanW'(mmp_pkg::TopLimit)) begin
        lu_q   <= lc_q;
        busy_q <= 1'b0;
      end else if ((spp_q > SppLimit) || (lc_q >= mmp_pkg::LuW'(mmp_pkg::MaxLevels))) begin
        busy_q <= 1'b0;
      end else if (nxt > (MaxPairs - tot_q)) begin
        busy_q <= 1'b0;
      end else begin
        spp_q <= spp_q << 2;
        cur_q <= nxt;
        tot_q <= tot_q + nxt;
        lc_q  <= lc_q + mmp_pkg::LuW'(1);
      end
    end
  end

  assign busy_o   = busy_q;
  assign levels_o = lu_q;

endmodule

@@ src/mmp_checker.sv @@
// port-level checks for the peak pyramid, bound to the top level
module mmp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input mmp_pkg::out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output item changed while stalled");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != mmp_pkg::STAT_OK) |->
      (out_data_i.level == '0) && (out_data_i.peak_min == '0) &&
      (out_data_i.peak_max == '0) && out_data_i.last_peak)
    else $error("malformed error item");

  a_plan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("input ready while planning");

endmodule

bind minmax_peak_pyramid mmp_checker u_mmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ verif/tb.sv @@
// testbench of the min/max peak pyramid: own prediction, random stimulus, scoreboard check
module tb;
  import mmp_pkg::*;

  // run bounds
  localparam int unsigned Limit       = 2000000;  // cycles before the run is called hung
  localparam int unsigned DrainCycles = 16;       // peak climb plus output register, with slack
  localparam int unsigned HoldCycles  = 300;      // one long output stall
  localparam int unsigned NumItems    = 320;      // input items sent over the whole run

  // mirror of the block: plan, per-level windows, and the queue of peaks still to come
  class peak_pyramid_twin;
    logic [CntW-1:0]         count_reg;
    int                      depth;
    logic signed [SampW-1:0] lo [MaxLevels];
    logic signed [SampW-1:0] hi [MaxLevels];
    int unsigned             fill [MaxLevels];
    int unsigned             seen;
    bit                      dead;
    out_item_t               due [$];
    int                      burst_len;
    int unsigned             made;
    int unsigned             checked;
    int unsigned             errors;
    int unsigned             top_seen;

    function new();
      count_reg = '0;
      depth     = 0;
      made      = 0;
      checked   = 0;
      errors    = 0;
      top_seen  = 0;
      restart();
    endfunction

    // levels needed for a sample count, 0 when the plan does not fit
    function int plan_depth(longint unsigned cnt);
      longint unsigned base, total, cur, spp;
      int              lc;
      base = cnt / BaseWindow + ((cnt % BaseWindow) != 0);
      if (base == 0 || base > MaxPeakPairs) return 0;
      total = base;
      cur   = base;
      spp   = BaseWindow;
      lc    = 1;
      while (cur > TopLimit) begin
        if (spp > 64'hFFFF_FFFF / GroupSize || lc >= MaxLevels) return 0;
        spp = spp * GroupSize;
        cur = (cur + GroupSize - 1) / GroupSize;
        if (cur > MaxPeakPairs - total) return 0;
        total = total + cur;
        lc++;
      end
      return lc;
    endfunction

    function void restart();
      for (int l = 0; l < MaxLevels; l++) begin
        lo[l]   = SampMax;
        hi[l]   = SampMin;
        fill[l] = 0;
      end
      seen = 0;
      dead = 1'b0;
    endfunction

    function void configure(logic [CntW-1:0] v);
      count_reg = v;
      depth     = plan_depth(longint'(v));
      restart();
    endfunction

    function void absorb(int l, logic signed [SampW-1:0] mn, logic signed [SampW-1:0] mx);
      if (mn < lo[l]) lo[l] = mn;
      if (mx > hi[l]) hi[l] = mx;
      fill[l]++;
    endfunction

    // emit the window of level l, hand it to the level above, empty it
    function void close_window(int l);
      out_item_t r;
      r.level     = LvlW'(l);
      r.peak_min  = lo[l];
      r.peak_max  = hi[l];
      r.last_peak = 1'b0;
      r.status    = STAT_OK;
      due = {due, r};
      burst_len++;
      if (l + 1 < depth) absorb(l + 1, lo[l], hi[l]);
      lo[l]   = SampMax;
      hi[l]   = SampMin;
      fill[l] = 0;
    endfunction

    // returns 1 when the item was used, 0 when the block ignores it
    function bit take_sample(in_item_t it);
      longint unsigned nxt;
      status_e         err;
      out_item_t       r;
      nxt = longint'(seen) + 1;
      if (dead) begin
        if (it.last_sample) restart();
        return 1'b0;
      end
      err = STAT_OK;
      if (depth == 0 || depth > MaxLevels) err = STAT_PLAN;
      else if (nxt > longint'(count_reg)) err = STAT_COUNT;
      else if (it.last_sample && nxt != longint'(count_reg)) err = STAT_COUNT;
      if (err != STAT_OK) begin
        r           = '0;
        r.last_peak = 1'b1;
        r.status    = err;
        due = {due, r};
        made++;
        if (it.last_sample) restart();
        else dead = 1'b1;
        return 1'b1;
      end
      burst_len = 0;
      seen = nxt[31:0];
      absorb(0, it.sample, it.sample);
      if (fill[0] >= BaseWindow) begin
        close_window(0);
        for (int l = 1; l < depth && fill[l] >= GroupSize; l++) close_window(l);
      end
      if (it.last_sample) begin
        for (int l = 0; l < depth; l++)
          if (fill[l] > 0) close_window(l);
        restart();
      end
      if (burst_len > 0) due[$].last_peak = 1'b1;
      made += burst_len;
      return 1'b1;
    endfunction

    function void match_peak(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        errors++;
        $error("peak with none due: level %0d min %0d max %0d status %0d",
               got.level, got.peak_min, got.peak_max, got.status);
        return;
      end
      want = due.pop_front();
      checked++;
      if (got.level > top_seen) top_seen = got.level;
      if (got.level !== want.level) begin
        errors++;
        $error("level: expected %0d, actual %0d", want.level, got.level);
      end
      if (got.peak_min !== want.peak_min) begin
        errors++;
        $error("peak_min: expected %0d, actual %0d", want.peak_min, got.peak_min);
      end
      if (got.peak_max !== want.peak_max) begin
        errors++;
        $error("peak_max: expected %0d, actual %0d", want.peak_max, got.peak_max);
      end
      if (got.last_peak !== want.last_peak) begin
        errors++;
        $error("last_peak: expected %0d, actual %0d", want.last_peak, got.last_peak);
      end
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;

  mmp_in_if  in_if ();
  mmp_out_if out_if ();

  minmax_peak_pyramid dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  peak_pyramid_twin sb;

  // run bookkeeping
  bit              send_gaps;
  bit              long_hold;
  logic [CntW-1:0] plan_count;
  int unsigned     n_sent;
  int unsigned     n_used;
  int unsigned     n_runs;
  int unsigned     n_cfg;
  int unsigned     cycle_cnt;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sample values lean on the extremes, zero and minus one
  function automatic logic signed [SampW-1:0] draw_sample();
    case ($urandom_range(0, 15))
      0:       return SampMin;
      1:       return SampMax;
      2:       return '0;
      3:       return '1;
      default: return SampW'($urandom());
    endcase
  endfunction

  // sample counts: mostly short runs, some around window edges, a few extremes
  function automatic logic [CntW-1:0] draw_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      3, 4:    return $urandom_range(250, 520);
      5:       return BaseWindow;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // offer one item, hold valid across back-to-back items, return once it is taken
  task automatic send_sample(input logic signed [SampW-1:0] s, input logic last);
    int       gap;
    in_item_t it;
    gap = send_gaps ? draw_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.sample      = s;
    it.last_sample = last;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    if (sb.take_sample(it)) n_used++;
  endtask

  // stop offering, drain every due peak, then let items with no peak finish too
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sample_count is only written while the block is idle
  task automatic write_count(input logic [CntW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(v);
    plan_count = v;
    n_cfg++;
  endtask

  // n random samples, last flag on the final one when asked
  task automatic send_run(input int n, input bit close);
    for (int i = 0; i < n; i++) send_sample(draw_sample(), close && i == n - 1);
  endtask

  // output side: random ready, calm stretches, and one long stall on request
  initial begin : peak_sink
    int quiet;
    int calm;
    int hold_left;
    bit hold_used;
    quiet     = 0;
    calm      = 0;
    hold_left = 0;
    hold_used = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.match_peak(out_if.data);
      if (long_hold && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (quiet > 0) begin
        quiet--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 63) == 0) calm = $urandom_range(20, 200);
        else if ($urandom_range(0, 3) == 0) quiet = draw_gap();
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int left;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    send_gaps   = 1'b1;
    long_hold   = 1'b0;
    plan_count  = '0;
    n_sent      = 0;
    n_used      = 0;
    n_runs      = 0;
    n_cfg       = 0;
    cycle_cnt   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // no plan after reset: first sample is a plan error, run stays dead until a last sample
    send_sample(SampMax, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SampMin, 1'b1);
    // plan error on a last sample ends the run at once
    send_sample('1, 1'b1);
    // empty plan
    write_count('0);
    send_sample(16'sd5, 1'b1);
    // one-sample runs at both extremes
    write_count(32'd1);
    send_sample(SampMin, 1'b1);
    send_sample(SampMax, 1'b1);
    // short run, flushed partial window
    write_count(32'd3);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd100, 1'b1);
    // too few samples: early last
    send_sample(16'sd42, 1'b1);
    // too many samples: the extra one kills the run, the last sample is swallowed
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(16'sd9, 1'b1);

    // --- long output stall while one-sample runs keep coming ---
    send_gaps = 1'b0;
    write_count(32'd1);
    long_hold <= 1'b1;
    send_run(1, 1'b1);
    for (int i = 0; i < 40; i++) send_run(1, 1'b1);
    send_gaps = 1'b1;

    // --- random runs: mostly well formed, some cut short, overrun or noisy ---
    n_used = 0;
    while (n_sent < NumItems) begin
      if (n_runs == 0 || $urandom_range(0, 2) == 0) write_count(draw_count());
      send_gaps = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      left = int'(NumItems) - int'(n_sent);
      if (plan_count == 0 || plan_count > 600 || int'(plan_count) > left + 16) begin
        // plan error or a plan too long for the items left: a short broken run
        send_run($urandom_range(1, 5), 1'b1);
      end else if (kind == 7) begin
        send_run($urandom_range(1, int'(plan_count)), 1'b1);
      end else if (kind == 8) begin
        send_run(int'(plan_count), 1'b0);
        send_run($urandom_range(1, 3), 1'b1);
      end else if (kind == 9) begin
        n = $urandom_range(0, 11);
        for (int i = 0; i < n; i++) send_sample(draw_sample(), $urandom_range(0, 3) == 0);
        send_sample(draw_sample(), 1'b1);
      end else begin
        send_run(int'(plan_count), 1'b1);
      end
      n_runs++;
    end

    settle();
    $display("summary: %0d items sent, %0d random runs, %0d sample_count writes, %0d used at random",
             n_sent, n_runs, n_cfg, n_used);
    $display("summary: %0d peaks checked up to level %0d, with one long output stall",
             sb.checked, sb.top_seen);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
